FILE: rtl/core/indexed_array_insert_erase_top_macros.svh
// Assertion macros used by the core datapath.
`ifndef INDEXED_ARRAY_INSERT_ERASE_TOP_MACROS_SVH
`define INDEXED_ARRAY_INSERT_ERASE_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define IAIE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define IAIE_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define IAIE_ASSERT_IMP(label, clk, rst, ante, cons)
`define IAIE_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

FILE: rtl/core/iaie_pkg.sv
package iaie_pkg;

   localparam int FIELD_W   = 6;
   localparam int WORD_W    = 32;
   localparam int RES_LIMIT = 32;

   localparam logic [1:0] FUNC_SET    = 2'd0;
   localparam logic [1:0] FUNC_INSERT = 2'd1;
   localparam logic [1:0] FUNC_ERASE  = 2'd2;
   localparam logic [1:0] FUNC_READ   = 2'd3;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_RANGE = 2'd1;
   localparam logic [1:0] STATUS_FULL  = 2'd2;

   typedef struct packed {
      logic [1:0]                func;
      logic [FIELD_W-1:0]        position;
      logic signed [WORD_W-1:0]  value;
      logic [FIELD_W-1:0]        size;
   } req_type;

   typedef struct packed {
      logic [1:0]                status;
      logic [FIELD_W-1:0]        index;
      logic signed [WORD_W-1:0]  data;
      logic [FIELD_W-1:0]        length;
      logic                      last;
   } rsp_type;

   typedef struct packed {
      logic capture;
      logic execute;
      logic slice_step;
   } ctl_cmd_type;

   typedef struct packed {
      logic is_slice;
      logic slice_last;
   } dp_stat_type;

endpackage

FILE: rtl/core/iaie_ctrl.sv
module iaie_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  iaie_pkg::dp_stat_type stat,
   output iaie_pkg::ctl_cmd_type cmd
);
   import iaie_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_EXEC  = 3'b010,
      ST_SLICE = 3'b100
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in       = state_ff;
      cmd            = '0;
      busy           = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
            state_in    = stat.is_slice ? ST_SLICE : ST_IDLE;
         end
         ST_SLICE: begin
            cmd.slice_step = 1'b1;
            if (stat.slice_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/iaie_datapath.sv
`include "indexed_array_insert_erase_top_macros.svh"

module iaie_datapath #(
   parameter int DEPTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  iaie_pkg::req_type     req_payload,
   input  iaie_pkg::ctl_cmd_type cmd,
   output iaie_pkg::dp_stat_type stat,
   output logic                  rsp_strobe,
   output iaie_pkg::rsp_type     rsp_payload
);
   import iaie_pkg::*;

   localparam int CW    = $clog2(DEPTH + 1);
   localparam int IW    = $clog2(DEPTH);
   localparam int CMP_W = FIELD_W + 1;

   req_type                  req_ff;
   logic [CW-1:0]            count_ff;
   logic [CW-1:0]            count_in;
   logic [IW-1:0]            ptr_ff;
   logic [FIELD_W-1:0]       remain_ff;
   logic signed [WORD_W-1:0] entries_ff [DEPTH];
   logic signed [WORD_W-1:0] entries_in [DEPTH];
   rsp_type                  rsp_ff;
   rsp_type                  rsp_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;

   logic [CMP_W-1:0] pos_w;
   logic [CMP_W-1:0] cnt_w;
   logic [CMP_W-1:0] end_w;
   logic [1:0]       status;
   logic             do_update;

   assign pos_w = {1'b0, req_ff.position};
   assign cnt_w = CMP_W'(count_ff);
   assign end_w = pos_w + {1'b0, req_ff.size};

   always_comb begin
      status = STATUS_OK;
      unique case (req_ff.func)
         FUNC_SET, FUNC_ERASE: begin
            if (pos_w >= cnt_w) begin
               status = STATUS_RANGE;
            end
         end
         FUNC_INSERT: begin
            priority if (pos_w > cnt_w) begin
               status = STATUS_RANGE;
            end else if (count_ff == CW'(DEPTH)) begin
               status = STATUS_FULL;
            end
         end
         FUNC_READ: begin
            if (pos_w >= cnt_w || end_w > cnt_w || req_ff.size > FIELD_W'(RES_LIMIT)) begin
               status = STATUS_RANGE;
            end
         end
         default: begin
            status = STATUS_OK;
         end
      endcase
   end

   assign stat.is_slice   = req_ff.func == FUNC_READ && status == STATUS_OK &&
                            req_ff.size != '0;
   assign stat.slice_last = remain_ff == FIELD_W'(1);
   assign do_update       = cmd.execute && status == STATUS_OK && req_ff.func != FUNC_READ;

   always_comb begin
      count_in = count_ff;
      if (do_update && req_ff.func == FUNC_INSERT) begin
         count_in = count_ff + CW'(1);
      end else if (do_update && req_ff.func == FUNC_ERASE) begin
         count_in = count_ff - CW'(1);
      end
   end

   for (genvar k = 0; k < DEPTH; k++) begin : g_entry
      localparam logic [CMP_W-1:0] KW = CMP_W'(k);
      logic signed [WORD_W-1:0] prev_word;
      logic signed [WORD_W-1:0] next_word;
      if (k > 0) begin : g_prev
         assign prev_word = entries_ff[k-1];
      end else begin : g_noprev
         assign prev_word = entries_ff[k];
      end
      if (k < DEPTH - 1) begin : g_next
         assign next_word = entries_ff[k+1];
      end else begin : g_nonext
         assign next_word = entries_ff[k];
      end
      always_comb begin
         entries_in[k] = entries_ff[k];
         if (do_update) begin
            unique case (req_ff.func)
               FUNC_SET: begin
                  if (KW == pos_w) begin
                     entries_in[k] = req_ff.value;
                  end
               end
               FUNC_INSERT: begin
                  priority if (KW == pos_w) begin
                     entries_in[k] = req_ff.value;
                  end else if (KW > pos_w && KW <= cnt_w) begin
                     entries_in[k] = prev_word;
                  end
               end
               FUNC_ERASE: begin
                  if (KW >= pos_w && KW + CMP_W'(1) < cnt_w) begin
                     entries_in[k] = next_word;
                  end
               end
               default: begin
                  entries_in[k] = entries_ff[k];
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      if (cmd.slice_step) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = STATUS_OK;
         rsp_in.index  = FIELD_W'(ptr_ff);
         rsp_in.data   = entries_ff[ptr_ff];
         rsp_in.length = FIELD_W'(count_ff);
         rsp_in.last   = stat.slice_last;
      end else if (cmd.execute && !stat.is_slice) begin
         rsp_valid_in  = 1'b1;
         rsp_in.status = status;
         rsp_in.index  = req_ff.position;
         rsp_in.data   = '0;
         rsp_in.length = FIELD_W'(count_in);
         rsp_in.last   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_payload;
      end
      if (cmd.execute) begin
         ptr_ff    <= req_ff.position[IW-1:0];
         remain_ff <= req_ff.size;
      end else if (cmd.slice_step) begin
         ptr_ff    <= ptr_ff + IW'(1);
         remain_ff <= remain_ff - FIELD_W'(1);
      end
      rsp_ff <= rsp_in;
      for (int k = 0; k < DEPTH; k++) begin
         entries_ff[k] <= entries_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_strobe  = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `IAIE_ASSERT_NXT(a_count_hold, clock, reset, !cmd.execute, $stable(count_ff))
   `IAIE_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   `IAIE_ASSERT_NXT(a_slice_emit, clock, reset, cmd.slice_step, rsp_valid_ff && rsp_ff.status == STATUS_OK)
   `IAIE_ASSERT_IMP(a_step_remain, clock, reset, cmd.slice_step, remain_ff != '0)

endmodule

FILE: rtl/core/indexed_array_insert_erase_top.sv
// A set, insert, erase or error result is registered in the execute state after the start
// transfer is taken in idle; slice results are registered in the slice state after execute.
// Busy holds off a new item until the controller is back in idle; a read slice gives
// one result per cycle from the store read mux.
// The store shifts all entries in parallel in a single update.
// Synchronous reset empties the array and clears the control; the receiver cannot stall.
module indexed_array_insert_erase_top #(
   parameter int DEPTH = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  iaie_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output iaie_pkg::rsp_type rsp_payload
);
   import iaie_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   iaie_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   iaie_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: sim/indexed_array_insert_erase_top_tb.sv
module indexed_array_insert_erase_top_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import iaie_pkg::*;

   localparam int STORE_DEPTH = 32;
   localparam int CYCLE_LIMIT = 400000;

   logic    clock = 1'b0;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_payload;
   logic    rsp_strobe;
   rsp_type rsp_payload;

   logic signed [WORD_W-1:0] store_words [STORE_DEPTH];
   int                       store_count;
   rsp_type                  expected_results [$];
   rsp_type                  oldest_result;
   int                       mismatch_count;
   int                       cycle_count;

   indexed_array_insert_erase_top #(
      .DEPTH(STORE_DEPTH)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_payload(req_payload),
      .rsp_strobe (rsp_strobe),
      .rsp_payload(rsp_payload)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic void predict_results(input req_type item);
      rsp_type r;
      int      pos;
      int      sz;
      r        = '0;
      pos      = item.position;
      sz       = item.size;
      r.index  = item.position;
      r.last   = 1'b1;
      r.status = STATUS_OK;
      case (item.func)
         FUNC_SET: begin
            if (pos >= store_count) r.status = STATUS_RANGE;
            else store_words[pos] = item.value;
         end
         FUNC_INSERT: begin
            if (pos > store_count) r.status = STATUS_RANGE;
            else if (store_count >= STORE_DEPTH) r.status = STATUS_FULL;
            else begin
               for (int i = store_count; i > pos; i--) store_words[i] = store_words[i-1];
               store_words[pos] = item.value;
               store_count++;
            end
         end
         FUNC_ERASE: begin
            if (pos >= store_count) r.status = STATUS_RANGE;
            else begin
               for (int i = pos; i + 1 < store_count; i++) store_words[i] = store_words[i+1];
               store_count--;
            end
         end
         default: begin
            if (pos >= store_count || pos + sz > store_count || sz > RES_LIMIT)
               r.status = STATUS_RANGE;
            else if (sz != 0) begin
               r.length = store_count[FIELD_W-1:0];
               for (int i = 0; i < sz; i++) begin
                  r.index = FIELD_W'(pos + i);
                  r.data  = store_words[pos+i];
                  r.last  = (i + 1 == sz);
                  expected_results.push_back(r);
               end
               return;
            end
         end
      endcase
      r.length = store_count[FIELD_W-1:0];
      expected_results.push_back(r);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: index %0d", rsp_payload.index);
            mismatch_count++;
         end else begin
            oldest_result = expected_results.pop_front();
            if (rsp_payload.status !== oldest_result.status) begin
               $error("status: expected %0d, actual %0d", oldest_result.status,
                      rsp_payload.status);
               mismatch_count++;
            end
            if (rsp_payload.index !== oldest_result.index) begin
               $error("index: expected %0d, actual %0d", oldest_result.index,
                      rsp_payload.index);
               mismatch_count++;
            end
            if (rsp_payload.data !== oldest_result.data) begin
               $error("data: expected %0d, actual %0d", oldest_result.data,
                      rsp_payload.data);
               mismatch_count++;
            end
            if (rsp_payload.length !== oldest_result.length) begin
               $error("length: expected %0d, actual %0d", oldest_result.length,
                      rsp_payload.length);
               mismatch_count++;
            end
            if (rsp_payload.last !== oldest_result.last) begin
               $error("last: expected %0d, actual %0d", oldest_result.last,
                      rsp_payload.last);
               mismatch_count++;
            end
         end
      end
   end

   task automatic send_item(input logic [1:0] func, input int pos,
                            input logic [WORD_W-1:0] val, input int sz,
                            input int idle_pct);
      req_type item;
      item.func     = func;
      item.position = pos[FIELD_W-1:0];
      item.value    = val;
      item.size     = sz[FIELD_W-1:0];
      start       <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (busy);
      predict_results(item);
      if ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // hold off until every expected transfer has come back
   task automatic wait_drained();
      start <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] pick_word();
      case ($urandom_range(0, 19))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic test_directed();
      send_item(FUNC_SET,     0, 32'h1111_1111,  0, 20);
      send_item(FUNC_ERASE,   0, 32'h0,          0, 20);
      send_item(FUNC_READ,    0, 32'h0,          0, 20);
      send_item(FUNC_INSERT,  1, 32'h2222_2222,  0, 20);
      send_item(FUNC_INSERT,  0, 32'h7FFF_FFFF,  0, 20);
      send_item(FUNC_INSERT,  1, 32'h8000_0000,  0, 20);
      send_item(FUNC_INSERT,  0, 32'hFFFF_FFFF,  0, 20);
      send_item(FUNC_INSERT,  3, 32'h1234_5678,  0, 20);
      send_item(FUNC_READ,    0, 32'h0,          4, 20);
      send_item(FUNC_READ,    2, 32'h0,          0, 20);
      send_item(FUNC_READ,    3, 32'h0,          2, 20);
      send_item(FUNC_READ,   63, 32'hFFFF_FFFF, 63, 20);
      send_item(FUNC_SET,     4, 32'h3333_3333,  0, 20);
      send_item(FUNC_SET,     1, 32'h0000_0000,  0, 20);
      send_item(FUNC_ERASE,   4, 32'h0,          0, 20);
      send_item(FUNC_ERASE,   1, 32'h0,          0, 20);
      send_item(FUNC_ERASE,   2, 32'h0,          0, 20);
      send_item(FUNC_INSERT, 63, 32'h4444_4444,  0, 20);
      send_item(FUNC_READ,    0, 32'h0,          2, 20);
      send_item(FUNC_INSERT,  2, 32'hA5A5_A5A5,  0, 20);
      send_item(FUNC_READ,    1, 32'h0,         33, 20);
      send_item(FUNC_SET,    63, 32'h5A5A_5A5A,  0, 20);
      send_item(FUNC_READ,    0, 32'h0,          3, 20);
      wait_drained();
   endtask

   task automatic test_full_store();
      while (store_count < STORE_DEPTH)
         send_item(FUNC_INSERT, $urandom_range(0, store_count), pick_word(), 0, 15);
      send_item(FUNC_INSERT,  0, pick_word(), 0, 15);
      send_item(FUNC_INSERT, 32, pick_word(), 0, 15);
      send_item(FUNC_INSERT, 33, pick_word(), 0, 15);
      send_item(FUNC_READ,    0, 32'h0,      32, 15);
      send_item(FUNC_READ,   31, 32'h0,       1, 15);
      send_item(FUNC_SET,    31, pick_word(), 0, 15);
      send_item(FUNC_READ,    0, 32'h0,      32, 15);
      while (store_count > 4)
         send_item(FUNC_ERASE, $urandom_range(0, store_count - 1), 32'h0, 0, 15);
      wait_drained();
   endtask

   task automatic test_random(input int count, input int grow_pct, input int idle_pct);
      int          sel;
      int          pos;
      int          sz;
      logic [1:0]  func;
      for (int n = 0; n < count; n++) begin
         sel = $urandom_range(0, 99);
         sz  = 0;
         if (sel < grow_pct) func = FUNC_INSERT;
         else if (sel < 60) func = FUNC_ERASE;
         else if (sel < 75) func = FUNC_SET;
         else func = FUNC_READ;
         if (func == FUNC_INSERT) pos = $urandom_range(0, store_count);
         else if (store_count == 0) pos = 0;
         else pos = $urandom_range(0, store_count - 1);
         if (func == FUNC_READ && store_count > pos) begin
            if ($urandom_range(0, 99) < 80)
               sz = $urandom_range(1, (store_count - pos < 4) ? store_count - pos : 4);
            else
               sz = $urandom_range(0, store_count - pos);
         end
         // malformed positions and sizes
         if ($urandom_range(0, 99) < 12) begin
            pos = $urandom_range(0, 63);
            sz  = $urandom_range(0, 63);
         end
         send_item(func, pos, pick_word(), sz, idle_pct);
      end
      wait_drained();
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_payload    = '0;
      store_count    = 0;
      mismatch_count = 0;
      cycle_count    = 0;
      foreach (store_words[i]) store_words[i] = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_store();
      test_random(110, 42, 32);
      test_random(110, 22, 46);
      test_random(110, 33, 0);
      if (mismatch_count == 0 && expected_results.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/iaie_pkg.sv
rtl/core/iaie_ctrl.sv
rtl/core/iaie_datapath.sv
rtl/core/indexed_array_insert_erase_top.sv
sim/indexed_array_insert_erase_top_tb.sv
